### src/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg: shared types and constants of the grid path search core
// Operation, status and register codes, default sizes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int DEF_GRID_W     = 8;
    localparam int DEF_GRID_H     = 8;
    localparam int DEF_OPEN_DEPTH = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int              COST_W    = 16;
    localparam logic [15:0]     COST_NONE = 16'hFFFF;
    localparam logic [15:0]     F_MAX     = 16'hFFFE;

    localparam logic [1:0] OP_MARK_STATIC  = 2'd0;
    localparam logic [1:0] OP_MARK_DYNAMIC = 2'd1;
    localparam logic [1:0] OP_CLEAR_DYN    = 2'd2;
    localparam logic [1:0] OP_SEARCH       = 2'd3;

    localparam logic [2:0] STS_PATH     = 3'd0;
    localparam logic [2:0] STS_ACK      = 3'd1;
    localparam logic [2:0] STS_NO_PATH  = 3'd2;
    localparam logic [2:0] STS_INVALID  = 3'd3;
    localparam logic [2:0] STS_OVERFLOW = 3'd4;

    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_WIDTH      = 3'd2;
    localparam logic [2:0] CFG_HEIGHT     = 3'd3;
    localparam logic [2:0] CFG_GRID_READY = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DEC, ST_MK_WR, ST_SR_G, ST_SR_S, ST_SWEEP, ST_SR_GO,
        ST_POP, ST_SCAN, ST_SHIFT, ST_POP_RD, ST_POP_CHK,
        ST_NB_GEN, ST_NB_CHK, ST_NB_SQ, ST_NB_EVAL, ST_NB_NEXT,
        ST_PW_RD, ST_PW_CHK, ST_EM_RD, ST_EM_OUT, ST_RES
    } t_state;

    typedef enum logic [1:0] {
        SW_CLR, SW_DYN, SW_INIT
    } t_sweep;

endpackage

### src/gaps_ram.sv
// ----------------------------------------------------------------------------
// gaps_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/gaps_isqrt.sv
// ----------------------------------------------------------------------------
// gaps_isqrt: iterative integer square root
// Produces one root bit per cycle, rounded down.
// ----------------------------------------------------------------------------
module gaps_isqrt #(
    parameter int RAD_W = 12,
    parameter int SQ_W  = RAD_W / 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_rad,
    output logic             o_done,
    output logic [SQ_W-1:0]  o_root
);
    localparam int CNT_W = $clog2(SQ_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [RAD_W-1:0] r_rad, n_rad;
    logic [SQ_W:0]    r_rem, n_rem;
    logic [SQ_W-1:0]  r_root, n_root;
    logic [SQ_W+2:0]  rem2, trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        rem2   = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(SQ_W);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            if (rem2 >= trial) begin
                n_rem  = (SQ_W+1)'(rem2 - trial);
                n_root = {r_root[SQ_W-2:0], 1'b1};
            end else begin
                n_rem  = rem2[SQ_W:0];
                n_root = {r_root[SQ_W-2:0], 1'b0};
            end
            n_rad = r_rad << 2;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### src/grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_core: A* path search on a small 8-connected grid
//
// A request is taken at a rising edge with start high and busy low. It marks a
// cell blocked (static or dynamic), clears all dynamic marks, or searches from
// the cell given to the goal. Results leave on o_valid for exactly one cycle
// each; the receiver cannot hold them off. A search yields the path cells from
// start to goal, o_last set on the goal, or one status result.
// Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user
// must write it only while busy is low, which the core does not enforce, and it
// takes effect on the next request. A dynamic clear keeps busy high while it
// sweeps the cell memory. A search first sweeps the cell memory, then per pop
// scans and compacts the open list (one entry per cycle through the open-list
// RAM port) and visits up to nine neighbours, each waiting on the iterative
// square root of the heuristic. The path is walked back from the goal to the
// start and then sent out from start to goal.
// After reset the cell memory is cleared in a pass during which busy is high;
// configuration writes are still taken then.
// ----------------------------------------------------------------------------
module grid_astar_path_search_core
    import gaps_pkg::*;
#(
    parameter int GRID_W     = DEF_GRID_W,
    parameter int GRID_H     = DEF_GRID_H,
    parameter int OPEN_DEPTH = DEF_OPEN_DEPTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_cell_x,
    input  logic [7:0] i_cell_y,
    input  logic [7:0] i_goal_x,
    input  logic [7:0] i_goal_y,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [7:0] o_path_x,
    output logic [7:0] o_path_y,
    output logic [2:0] o_status,
    output logic       o_last
);
    // Sizes follow from the grid and the fixed-point format.
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int CX_W   = $clog2(GRID_W);
    localparam int CY_W   = $clog2(GRID_H);
    localparam int PC_W   = CX_W + CY_W;          // packed {y, x} cell
    localparam int CELL_W = $clog2(NCELLS);
    localparam int KCNT_W = $clog2(NCELLS + 1);
    localparam int G_W    = $clog2(NCELLS + 1);
    localparam int OP_AW  = $clog2(OPEN_DEPTH);
    localparam int OCNT_W = $clog2(OPEN_DEPTH + 1);
    localparam int D_W    = (CX_W > CY_W) ? CX_W : CY_W;
    localparam int SUM_W  = 2 * D_W + 1;
    localparam int RAW_W  = SUM_W + 2 * FRAC_BITS;
    localparam int RAD_W  = RAW_W + (RAW_W % 2);
    localparam int SQ_W   = RAD_W / 2;
    localparam int GF_W   = G_W + FRAC_BITS;
    localparam int FV_W   = ((GF_W > SQ_W) ? GF_W : SQ_W) + 1;

    // Cell word: {dynamic, blocked, closed, best cost, parent}.
    localparam int CW_W  = 3 + COST_W + PC_W;
    localparam int B_CL  = PC_W + COST_W;
    localparam int B_BL  = B_CL + 1;
    localparam int B_DY  = B_CL + 2;
    // Open-list entry: {f, g, cell}.
    localparam int OE_W  = COST_W + G_W + PC_W;
    localparam int OE_F  = PC_W + G_W;

    function automatic logic [CELL_W-1:0] cidx(input logic [PC_W-1:0] pc);
        cidx = CELL_W'(int'(pc[PC_W-1:CX_W]) * GRID_W + int'(pc[CX_W-1:0]));
    endfunction

    function automatic logic [8:0] span(input logic [3:0] cnt, input int grid,
                                        input logic [7:0] org);
        logic [8:0] n;
        logic [8:0] room;
        n    = {5'd0, cnt};
        room = 9'd256 - {1'b0, org};
        if (n > 9'(grid)) n = 9'(grid);
        if (n > room) n = room;
        span = n;
    endfunction

    // ---------------------------------------------------------------- registers
    t_state r_state, n_state;
    t_sweep r_mode, n_mode;
    logic [1:0]        r_op, n_op;
    logic [7:0]        r_x, n_x, r_y, n_y, r_gx, n_gx, r_gy, n_gy;
    logic [7:0]        r_org_x, r_org_y;
    logic [3:0]        r_wuse, r_huse;
    logic              r_ready;
    logic [KCNT_W-1:0] r_sw, n_sw;
    logic              r_pv, n_pv;
    logic [CELL_W-1:0] r_pidx, n_pidx;
    logic [OCNT_W-1:0] r_oi, n_oi, r_count, n_count;
    logic              r_opv, n_opv;
    logic [OP_AW-1:0]  r_opi, n_opi, r_best, n_best;
    logic [COST_W-1:0] r_minf, n_minf;
    logic [OE_W-1:0]   r_node, n_node;
    logic              r_gblk, n_gblk;
    logic [1:0]        r_dxi, n_dxi, r_dyi, n_dyi;
    logic [PC_W-1:0]   r_nb, n_nb, r_cur, n_cur;
    logic [CW_W-1:0]   r_word, n_word;
    logic [SQ_W-1:0]   r_h, n_h;
    logic [KCNT_W-1:0] r_k, n_k;
    logic [2:0]        r_status, n_status;
    logic              r_ov, n_ov, r_ol, n_ol;
    logic [7:0]        r_ox, n_ox, r_oy, n_oy;
    logic [2:0]        r_os, n_os;

    // ---------------------------------------------------------------- memories
    logic              cm_we;
    logic [CELL_W-1:0] cm_waddr, cm_raddr;
    logic [CW_W-1:0]   cm_wdata, cm_rdata;
    logic              om_we;
    logic [OP_AW-1:0]  om_waddr, om_raddr;
    logic [OE_W-1:0]   om_wdata, om_rdata;
    logic              sm_we;
    logic [CELL_W-1:0] sm_waddr, sm_raddr;
    logic [PC_W-1:0]   sm_wdata, sm_rdata;

    gaps_ram #(.WIDTH(CW_W), .DEPTH(NCELLS)) u_cell_ram (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_waddr), .i_wdata(cm_wdata),
        .i_raddr(cm_raddr), .o_rdata(cm_rdata)
    );
    gaps_ram #(.WIDTH(OE_W), .DEPTH(OPEN_DEPTH)) u_open_ram (
        .i_clk(i_clk), .i_we(om_we), .i_waddr(om_waddr), .i_wdata(om_wdata),
        .i_raddr(om_raddr), .o_rdata(om_rdata)
    );
    gaps_ram #(.WIDTH(PC_W), .DEPTH(NCELLS)) u_stack_ram (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr(sm_waddr), .i_wdata(sm_wdata),
        .i_raddr(sm_raddr), .o_rdata(sm_rdata)
    );

    // ------------------------------------------------------ location of cells
    logic [8:0]      w_span, h_span;
    logic [7:0]      lsx, lsy, lgx, lgy;
    logic            loc_s, loc_g;
    logic [PC_W-1:0] s_pc, g_pc;

    assign w_span = span(r_wuse, GRID_W, r_org_x);
    assign h_span = span(r_huse, GRID_H, r_org_y);
    assign lsx = r_x - r_org_x;
    assign lsy = r_y - r_org_y;
    assign lgx = r_gx - r_org_x;
    assign lgy = r_gy - r_org_y;
    assign loc_s = (r_x >= r_org_x) && (r_y >= r_org_y) &&
                   ({1'b0, lsx} < w_span) && ({1'b0, lsy} < h_span);
    assign loc_g = (r_gx >= r_org_x) && (r_gy >= r_org_y) &&
                   ({1'b0, lgx} < w_span) && ({1'b0, lgy} < h_span);
    assign s_pc = {lsy[CY_W-1:0], lsx[CX_W-1:0]};
    assign g_pc = {lgy[CY_W-1:0], lgx[CX_W-1:0]};

    // ------------------------------------------------------ neighbour stepping
    // Offsets are held as 0..2 standing for -1..+1, so coordinate + offset
    // is in the grid when it lies in 1..span.
    logic [CX_W+1:0] tx;
    logic [CY_W+1:0] ty;
    logic            nb_ok;
    logic [PC_W-1:0] nb_pc;
    logic [PC_W-1:0] node_pc;

    assign node_pc = r_node[PC_W-1:0];
    assign tx = {2'b00, node_pc[CX_W-1:0]} + (CX_W+2)'(r_dxi);
    assign ty = {2'b00, node_pc[PC_W-1:CX_W]} + (CY_W+2)'(r_dyi);
    assign nb_ok = (tx != '0) && (9'(tx) <= w_span) && (ty != '0) && (9'(ty) <= h_span);
    assign nb_pc = {CY_W'(ty - 1'b1), CX_W'(tx - 1'b1)};

    // -------------------------------------------------------------- heuristic
    logic [D_W-1:0]   nxx, nyy, gxx, gyy, adx, ady;
    logic [SUM_W-1:0] dsum;
    logic [RAD_W-1:0] rad;
    logic             sq_start, sq_done;
    logic [SQ_W-1:0]  sq_root;

    assign nxx = D_W'(r_nb[CX_W-1:0]);
    assign nyy = D_W'(r_nb[PC_W-1:CX_W]);
    assign gxx = D_W'(g_pc[CX_W-1:0]);
    assign gyy = D_W'(g_pc[PC_W-1:CX_W]);
    assign adx = (nxx > gxx) ? nxx - gxx : gxx - nxx;
    assign ady = (nyy > gyy) ? nyy - gyy : gyy - nyy;
    assign dsum = SUM_W'(adx * adx) + SUM_W'(ady * ady);
    assign rad = RAD_W'(dsum) << (2 * FRAC_BITS);

    gaps_isqrt #(.RAD_W(RAD_W), .SQ_W(SQ_W)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_rad(rad),
        .o_done(sq_done), .o_root(sq_root)
    );

    // f = (g << FRAC_BITS) + h, saturated below the unreached mark.
    logic [G_W-1:0]    g_new;
    logic [FV_W-1:0]   fv;
    logic [COST_W-1:0] fsat;
    logic              better, full;

    assign g_new  = r_node[PC_W +: G_W] + 1'b1;
    assign fv     = (FV_W'(g_new) << FRAC_BITS) + FV_W'(r_h);
    assign fsat   = (fv > FV_W'(F_MAX)) ? F_MAX : COST_W'(fv);
    assign better = fsat < r_word[PC_W +: COST_W];
    assign full   = r_count == OCNT_W'(OPEN_DEPTH);

    // ------------------------------------------------------------ end markers
    logic sw_done, scan_done;
    assign sw_done = (r_mode == SW_CLR) ? (r_sw == KCNT_W'(NCELLS - 1))
                                        : ((r_sw == KCNT_W'(NCELLS)) && !r_pv);
    assign scan_done = (r_oi == r_count) && !r_opv;

    // ------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (start) n_state = ST_DEC;
            ST_DEC: begin
                unique case (r_op)
                    OP_MARK_STATIC, OP_MARK_DYNAMIC:
                        n_state = loc_s ? ST_MK_WR : ST_RES;
                    OP_CLEAR_DYN: n_state = ST_SWEEP;
                    OP_SEARCH:
                        n_state = (r_ready && loc_g && loc_s) ? ST_SR_G : ST_RES;
                    default: n_state = ST_RES;
                endcase
            end
            ST_MK_WR:   n_state = ST_RES;
            ST_SR_G:    n_state = ST_SR_S;
            ST_SR_S: begin
                if (r_gblk || cm_rdata[B_BL] || (s_pc == g_pc)) n_state = ST_RES;
                else n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (sw_done) begin
                    unique case (r_mode)
                        SW_CLR:  n_state = ST_IDLE;
                        SW_DYN:  n_state = ST_RES;
                        SW_INIT: n_state = ST_SR_GO;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SR_GO:   n_state = ST_POP;
            ST_POP:     n_state = (r_count == '0) ? ST_RES : ST_SCAN;
            ST_SCAN:    if (scan_done) n_state = ST_SHIFT;
            ST_SHIFT:   if (scan_done) n_state = ST_POP_RD;
            ST_POP_RD:  n_state = ST_POP_CHK;
            ST_POP_CHK: n_state = cm_rdata[B_BL] ? ST_POP : ST_NB_GEN;
            ST_NB_GEN:  n_state = nb_ok ? ST_NB_CHK : ST_NB_NEXT;
            ST_NB_CHK: begin
                priority if (cm_rdata[B_BL]) n_state = ST_NB_NEXT;
                else if (r_nb == g_pc)       n_state = ST_PW_RD;
                else if (cm_rdata[B_CL])     n_state = ST_NB_NEXT;
                else                         n_state = ST_NB_SQ;
            end
            ST_NB_SQ:   if (sq_done) n_state = ST_NB_EVAL;
            ST_NB_EVAL: n_state = (better && full) ? ST_RES : ST_NB_NEXT;
            ST_NB_NEXT:
                n_state = (r_dxi == 2'd2 && r_dyi == 2'd2) ? ST_POP : ST_NB_GEN;
            ST_PW_RD:   n_state = ST_PW_CHK;
            ST_PW_CHK: begin
                if (cm_rdata[PC_W-1:0] == r_cur || r_k == KCNT_W'(NCELLS))
                    n_state = ST_EM_RD;
                else
                    n_state = ST_PW_RD;
            end
            ST_EM_RD:   n_state = ST_EM_OUT;
            ST_EM_OUT:  n_state = (r_k == KCNT_W'(1)) ? ST_IDLE : ST_EM_RD;
            ST_RES:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------- datapath and outputs
    always_comb begin
        n_mode = r_mode;   n_op = r_op;
        n_x = r_x;  n_y = r_y;  n_gx = r_gx;  n_gy = r_gy;
        n_sw = r_sw;  n_pv = 1'b0;  n_pidx = r_pidx;
        n_oi = r_oi;  n_opv = 1'b0;  n_opi = r_opi;  n_count = r_count;
        n_best = r_best;  n_minf = r_minf;  n_node = r_node;
        n_gblk = r_gblk;  n_dxi = r_dxi;  n_dyi = r_dyi;
        n_nb = r_nb;  n_cur = r_cur;  n_word = r_word;  n_h = r_h;  n_k = r_k;
        n_status = r_status;
        n_ov = 1'b0;  n_ox = '0;  n_oy = '0;  n_os = STS_PATH;  n_ol = 1'b0;
        cm_we = 1'b0;  cm_waddr = '0;  cm_wdata = cm_rdata;  cm_raddr = '0;
        om_we = 1'b0;  om_waddr = '0;  om_wdata = om_rdata;  om_raddr = '0;
        sm_we = 1'b0;  sm_waddr = r_k[CELL_W-1:0];  sm_wdata = r_cur;
        sm_raddr = CELL_W'(r_k - 1'b1);
        sq_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op = i_opcode;  n_x = i_cell_x;  n_y = i_cell_y;
                    n_gx = i_goal_x;  n_gy = i_goal_y;
                end
            end
            ST_DEC: begin
                n_status = STS_INVALID;
                n_sw = '0;
                n_mode = SW_DYN;
                cm_raddr = (r_op == OP_SEARCH) ? cidx(g_pc) : cidx(s_pc);
            end
            ST_MK_WR: begin
                cm_we = 1'b1;
                cm_waddr = cidx(s_pc);
                cm_wdata[B_BL] = 1'b1;
                if (r_op == OP_MARK_DYNAMIC) cm_wdata[B_DY] = 1'b1;
                n_status = STS_ACK;
            end
            ST_SR_G: begin
                n_gblk = cm_rdata[B_BL];
                cm_raddr = cidx(s_pc);
            end
            ST_SR_S: begin
                n_status = (r_gblk || cm_rdata[B_BL]) ? STS_NO_PATH : STS_INVALID;
                n_mode = SW_INIT;
                n_sw = '0;
            end
            ST_SWEEP: begin
                if (r_mode == SW_CLR) begin
                    cm_we = 1'b1;
                    cm_waddr = r_sw[CELL_W-1:0];
                    cm_wdata = '0;
                    cm_wdata[PC_W +: COST_W] = COST_NONE;
                    n_sw = r_sw + 1'b1;
                end else begin
                    if (r_sw != KCNT_W'(NCELLS)) begin
                        cm_raddr = r_sw[CELL_W-1:0];
                        n_sw = r_sw + 1'b1;
                        n_pv = 1'b1;
                        n_pidx = r_sw[CELL_W-1:0];
                    end
                    if (r_pv) begin
                        cm_we = 1'b1;
                        cm_waddr = r_pidx;
                        if (r_mode == SW_DYN) begin
                            if (cm_rdata[B_DY]) begin
                                cm_wdata[B_DY] = 1'b0;
                                cm_wdata[B_BL] = 1'b0;
                            end
                        end else begin
                            cm_wdata[B_CL] = 1'b0;
                            if (r_pidx == cidx(s_pc)) begin
                                cm_wdata[PC_W +: COST_W] = '0;
                                cm_wdata[PC_W-1:0] = s_pc;
                            end else begin
                                cm_wdata[PC_W +: COST_W] = COST_NONE;
                            end
                        end
                    end
                end
                n_status = STS_ACK;
            end
            ST_SR_GO: begin
                om_we = 1'b1;
                om_waddr = '0;
                om_wdata = {COST_W'(0), G_W'(0), s_pc};
                n_count = OCNT_W'(1);
            end
            ST_POP: begin
                n_status = STS_NO_PATH;
                n_oi = '0;
                n_minf = COST_NONE;
                n_best = '0;
            end
            ST_SCAN: begin
                if (r_oi != r_count) begin
                    om_raddr = r_oi[OP_AW-1:0];
                    n_oi = r_oi + 1'b1;
                    n_opv = 1'b1;
                    n_opi = r_oi[OP_AW-1:0];
                end
                // Strict compare keeps the earliest of equal minima.
                if (r_opv && om_rdata[OE_F +: COST_W] < r_minf) begin
                    n_minf = om_rdata[OE_F +: COST_W];
                    n_best = r_opi;
                    n_node = om_rdata;
                end
                if (scan_done) n_oi = OCNT_W'(r_best) + 1'b1;
            end
            ST_SHIFT: begin
                // Close the gap left by the popped entry, one entry a cycle.
                if (r_oi != r_count) begin
                    om_raddr = r_oi[OP_AW-1:0];
                    n_oi = r_oi + 1'b1;
                    n_opv = 1'b1;
                    n_opi = r_oi[OP_AW-1:0];
                end
                if (r_opv) begin
                    om_we = 1'b1;
                    om_waddr = r_opi - 1'b1;
                    om_wdata = om_rdata;
                end
                if (scan_done) n_count = r_count - 1'b1;
            end
            ST_POP_RD: cm_raddr = cidx(node_pc);
            ST_POP_CHK: begin
                if (!cm_rdata[B_BL]) begin
                    cm_we = 1'b1;
                    cm_waddr = cidx(node_pc);
                    cm_wdata[B_CL] = 1'b1;
                end
                n_dxi = '0;
                n_dyi = '0;
            end
            ST_NB_GEN: begin
                cm_raddr = cidx(nb_pc);
                n_nb = nb_pc;
            end
            ST_NB_CHK: begin
                n_word = cm_rdata;
                if (!cm_rdata[B_BL] && r_nb == g_pc) begin
                    cm_we = 1'b1;
                    cm_waddr = cidx(r_nb);
                    cm_wdata[PC_W-1:0] = node_pc;
                    n_cur = g_pc;
                    n_k = '0;
                end else if (!cm_rdata[B_BL] && !cm_rdata[B_CL]) begin
                    sq_start = 1'b1;
                end
            end
            ST_NB_SQ: if (sq_done) n_h = sq_root;
            ST_NB_EVAL: begin
                n_status = STS_OVERFLOW;
                if (better) begin
                    cm_we = 1'b1;
                    cm_waddr = cidx(r_nb);
                    cm_wdata = {r_word[B_DY:B_CL], fsat, node_pc};
                    if (!full) begin
                        om_we = 1'b1;
                        om_waddr = r_count[OP_AW-1:0];
                        om_wdata = {fsat, g_new, r_nb};
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_NB_NEXT: begin
                if (r_dyi == 2'd2) begin
                    n_dyi = '0;
                    n_dxi = r_dxi + 1'b1;
                end else begin
                    n_dyi = r_dyi + 1'b1;
                end
            end
            ST_PW_RD: begin
                sm_we = 1'b1;
                cm_raddr = cidx(r_cur);
                n_k = r_k + 1'b1;
            end
            ST_PW_CHK: n_cur = cm_rdata[PC_W-1:0];
            ST_EM_RD: ;
            ST_EM_OUT: begin
                n_ov = 1'b1;
                n_ox = r_org_x + 8'(sm_rdata[CX_W-1:0]);
                n_oy = r_org_y + 8'(sm_rdata[PC_W-1:CX_W]);
                n_os = STS_PATH;
                n_ol = (r_k == KCNT_W'(1));
                n_k = r_k - 1'b1;
            end
            ST_RES: begin
                n_ov = 1'b1;
                n_os = r_status;
                n_ol = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_mode  <= SW_CLR;
            r_sw    <= '0;
            r_pv    <= 1'b0;
            r_opv   <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_wuse  <= 4'd8;
            r_huse  <= 4'd8;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_sw    <= n_sw;
            r_pv    <= n_pv;
            r_opv   <= n_opv;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ORIGIN_X:   r_org_x <= i_cfg_wdata;
                    CFG_ORIGIN_Y:   r_org_y <= i_cfg_wdata;
                    CFG_WIDTH:      r_wuse  <= i_cfg_wdata[3:0];
                    CFG_HEIGHT:     r_huse  <= i_cfg_wdata[3:0];
                    CFG_GRID_READY: r_ready <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        r_op <= n_op;  r_x <= n_x;  r_y <= n_y;  r_gx <= n_gx;  r_gy <= n_gy;
        r_pidx <= n_pidx;  r_oi <= n_oi;  r_opi <= n_opi;  r_best <= n_best;
        r_minf <= n_minf;  r_node <= n_node;  r_gblk <= n_gblk;
        r_dxi <= n_dxi;  r_dyi <= n_dyi;  r_nb <= n_nb;  r_cur <= n_cur;
        r_word <= n_word;  r_h <= n_h;  r_k <= n_k;  r_status <= n_status;
        r_ox <= n_ox;  r_oy <= n_oy;  r_os <= n_os;  r_ol <= n_ol;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_ov;
    assign o_path_x = r_ox;
    assign o_path_y = r_oy;
    assign o_status = r_os;
    assign o_last   = r_ol;
endmodule

### src/gaps_checker.sv
// ----------------------------------------------------------------------------
// gaps_checker: port-level checks of the grid path search core
// Watches requests and result strobes on the top level.
// ----------------------------------------------------------------------------
module gaps_checker
    import gaps_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_path_x,
    input logic [7:0] o_path_y,
    input logic [2:0] o_status,
    input logic       o_last
);
    // A status result is a lone, final result with zero coordinates.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_PATH |-> o_last && o_path_x == 8'd0 && o_path_y == 8'd0)
        else $error("status result not final or carries coordinates");

    // A taken request keeps the core busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but core not busy");

    // The final result of a request is followed by a quiet cycle.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result strobe right after a final result");

    // Reset starts the clearing pass.
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy && !o_valid)
        else $error("core not busy after reset");
endmodule

bind grid_astar_path_search_core gaps_checker u_gaps_checker (.*);

### bench/astar_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_result_checker: result prediction and comparison for the path search
// Watches the request, configuration and result ports of the path search core.
// It keeps its own copy of the grid state and replays each accepted request
// through a behavioural A* search. Every result is then compared with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module astar_result_checker
    import gaps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_cell_x,
    input  logic [7:0] i_cell_y,
    input  logic [7:0] i_goal_x,
    input  logic [7:0] i_goal_y,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    input  logic [7:0] i_path_x,
    input  logic [7:0] i_path_y,
    input  logic [2:0] i_status,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_waiting
);

    localparam int GW     = DEF_GRID_W;
    localparam int GH     = DEF_GRID_H;
    localparam int CELLS  = GW * GH;
    localparam int ODEPTH = DEF_OPEN_DEPTH;
    localparam int FBITS  = DEF_FRAC_BITS;

    typedef struct {
        logic [7:0] px;
        logic [7:0] py;
        logic [2:0] sts;
        logic       last;
    } t_route_res;

    t_route_res due_results[$];

    logic [7:0] org_x, org_y;
    logic [3:0] use_w, use_h;
    logic       ready;
    bit         blocked[CELLS];
    bit         dyn_mark[CELLS];
    bit         closed[CELLS];
    int         cost_f[CELLS];
    int         from_cell[CELLS];
    int         open_f[ODEPTH];
    int         open_g[ODEPTH];
    int         open_c[ODEPTH];
    int         open_n;

    assign o_waiting = due_results.size();

    function automatic int span_of(int use_n, int grid_n, int org);
        int n;
        n = use_n;
        if (n > grid_n) n = grid_n;
        if (n > 256 - org) n = 256 - org;
        return n;
    endfunction

    function automatic bit cell_index(int x, int y, output int idx);
        int w, h;
        w = span_of(use_w, GW, org_x);
        h = span_of(use_h, GH, org_y);
        idx = 0;
        if (x < org_x || y < org_y) return 0;
        if (x - org_x >= w || y - org_y >= h) return 0;
        idx = (y - org_y) * GW + (x - org_x);
        return 1;
    endfunction

    function automatic int int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return int'(r);
    endfunction

    function automatic int euclid_h(int a, int b);
        longint unsigned dx, dy;
        dx = (a % GW > b % GW) ? a % GW - b % GW : b % GW - a % GW;
        dy = (a / GW > b / GW) ? a / GW - b / GW : b / GW - a / GW;
        return int_sqrt((dx * dx + dy * dy) << (2 * FBITS));
    endfunction

    function automatic void push_status(logic [2:0] sts);
        t_route_res r;
        r.px = '0; r.py = '0; r.sts = sts; r.last = 1'b1;
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void push_route(int goal);
        int chain[$];
        int cur;
        t_route_res r;
        cur = goal;
        while (chain.size() < CELLS) begin
            chain.push_front(cur);
            if (from_cell[cur] == cur) break;
            cur = from_cell[cur] % CELLS;
        end
        foreach (chain[i]) begin
            r.px = 8'(org_x + chain[i] % GW);
            r.py = 8'(org_y + chain[i] / GW);
            r.sts = STS_PATH;
            r.last = (i == chain.size() - 1);
            due_results.insert(due_results.size(), r);
        end
    endfunction

    // Open-list search; stale duplicates stay in the list and the earliest
    // entry of minimum f wins. Blocked pops are thrown away.
    function automatic void run_search(int s, int goal);
        int w, h, best, minf, node_c, node_g, nx, ny, n, g;
        longint unsigned fv;
        w = span_of(use_w, GW, org_x);
        h = span_of(use_h, GH, org_y);
        for (int i = 0; i < CELLS; i++) begin
            closed[i] = 0;
            cost_f[i] = 'hFFFF;
        end
        cost_f[s] = 0;
        from_cell[s] = s;
        open_f[0] = 0; open_g[0] = 0; open_c[0] = s;
        open_n = 1;
        forever begin
            do begin
                if (open_n == 0) begin
                    push_status(STS_NO_PATH);
                    return;
                end
                best = 0;
                minf = 'hFFFF;
                for (int i = 0; i < open_n; i++)
                    if (open_f[i] < minf) begin
                        minf = open_f[i];
                        best = i;
                    end
                node_c = open_c[best];
                node_g = open_g[best];
                for (int i = best; i < open_n - 1; i++) begin
                    open_f[i] = open_f[i+1];
                    open_g[i] = open_g[i+1];
                    open_c[i] = open_c[i+1];
                end
                open_n--;
            end while (blocked[node_c]);
            closed[node_c] = 1;
            for (int dx = -1; dx <= 1; dx++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    nx = node_c % GW + dx;
                    ny = node_c / GW + dy;
                    if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                    n = ny * GW + nx;
                    if (blocked[n]) continue;
                    if (n == goal) begin
                        from_cell[n] = node_c;
                        push_route(goal);
                        return;
                    end
                    if (closed[n]) continue;
                    g = node_g + 1;
                    fv = (longint'(g) << FBITS) + euclid_h(n, goal);
                    if (fv > F_MAX) fv = F_MAX;
                    if (int'(fv) < cost_f[n]) begin
                        cost_f[n] = int'(fv);
                        from_cell[n] = node_c;
                        if (open_n >= ODEPTH) begin
                            push_status(STS_OVERFLOW);
                            return;
                        end
                        open_f[open_n] = int'(fv);
                        open_g[open_n] = g;
                        open_c[open_n] = n;
                        open_n++;
                    end
                end
            end
        end
    endfunction

    function automatic void predict_request(logic [1:0] op, int x, int y, int gx, int gy);
        int s, g;
        bit s_ok, g_ok;
        if (op == OP_MARK_STATIC || op == OP_MARK_DYNAMIC) begin
            if (!cell_index(x, y, s)) begin
                push_status(STS_INVALID);
            end else begin
                blocked[s] = 1;
                if (op == OP_MARK_DYNAMIC) dyn_mark[s] = 1;
                push_status(STS_ACK);
            end
        end else if (op == OP_CLEAR_DYN) begin
            for (int i = 0; i < CELLS; i++)
                if (dyn_mark[i]) begin
                    blocked[i] = 0;
                    dyn_mark[i] = 0;
                end
            push_status(STS_ACK);
        end else begin
            g_ok = cell_index(gx, gy, g);
            s_ok = cell_index(x, y, s);
            if (!ready || !g_ok || !s_ok) push_status(STS_INVALID);
            else if (blocked[g] || blocked[s]) push_status(STS_NO_PATH);
            else if (s == g) push_status(STS_INVALID);
            else run_search(s, g);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_route_res want;
        if (!i_rst_n) begin
            org_x <= 8'd0; org_y <= 8'd0; use_w <= 4'd8; use_h <= 4'd8; ready <= 1'b0;
            for (int i = 0; i < CELLS; i++) begin
                blocked[i] = 0;
                dyn_mark[i] = 0;
                from_cell[i] = 0;
            end
            due_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ORIGIN_X:   org_x <= i_cfg_wdata;
                    CFG_ORIGIN_Y:   org_y <= i_cfg_wdata;
                    CFG_WIDTH:      use_w <= i_cfg_wdata[3:0];
                    CFG_HEIGHT:     use_h <= i_cfg_wdata[3:0];
                    CFG_GRID_READY: ready <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    $display("%0t result with no request outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_path_x !== want.px) report_mismatch("path_x", i_path_x, want.px);
                    if (i_path_y !== want.py) report_mismatch("path_y", i_path_y, want.py);
                    if (i_status !== want.sts) report_mismatch("status", i_status, want.sts);
                    if (i_last !== want.last) report_mismatch("last", i_last, want.last);
                end
            end
            if (i_start && !i_busy)
                predict_request(i_opcode, i_cell_x, i_cell_y, i_goal_x, i_goal_y);
        end
    end

endmodule

### bench/tb_grid_astar_path_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search_core: stimulus and verdict for the path search core
// Drives a directed opening of marks, clears and searches, then random
// traffic over several grid settings with varying request gaps. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search_core;
    import gaps_pkg::*;

    // Cycles without any request or result taken before the run is abandoned.
    // A single search on the 8x8 grid needs far less than this, even with a
    // long open list.
    localparam int STALL_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_opcode;
    logic [7:0] i_cell_x, i_cell_y, i_goal_x, i_goal_y;
    logic       i_cfg_we;
    logic [2:0] i_cfg_addr;
    logic [7:0] i_cfg_wdata;
    logic       o_valid;
    logic [7:0] o_path_x, o_path_y;
    logic [2:0] o_status;
    logic       o_last;
    int         fail_count;
    int         waiting;
    int         quiet_cycles;

    // Stimulus-side copy of the grid settings, used only to aim coordinates.
    int         cur_ox, cur_oy, cur_w, cur_h;

    grid_astar_path_search_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_cell_x   (i_cell_x),
        .i_cell_y   (i_cell_y),
        .i_goal_x   (i_goal_x),
        .i_goal_y   (i_goal_y),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_path_x   (o_path_x),
        .o_path_y   (o_path_y),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    astar_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_opcode    (i_opcode),
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .i_goal_x    (i_goal_x),
        .i_goal_y    (i_goal_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (o_valid),
        .i_path_x    (o_path_x),
        .i_path_y    (o_path_y),
        .i_status    (o_status),
        .i_last      (o_last),
        .o_fail_count(fail_count),
        .o_waiting   (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any accepted request or delivered result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL grid_astar_path_search_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A request is presented at a falling edge and held until a rising edge
    // finds busy low. Busy is stable at the falling edge, so checking it there
    // tells us whether the coming rising edge takes the request.
    task automatic send_request(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                logic [7:0] gx, logic [7:0] gy);
        @(negedge i_clk);
        start    <= 1'b1;
        i_opcode <= op;
        i_cell_x <= x;
        i_cell_y <= y;
        i_goal_x <= gx;
        i_goal_y <= gy;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Optional gap between requests; gaps of zero keep start high back to back.
    task automatic sender_gap(int pct);
        if ($urandom_range(0, 99) < pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    // Lets every outstanding result drain and the core settle before the
    // settings change. Every request yields at least one result, so an empty
    // expectation store plus busy low means the core is idle.
    task automatic drain_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (waiting != 0 || busy) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_grid(int ox, int oy, int w, int h, bit rdy);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= CFG_ORIGIN_X;   i_cfg_wdata <= 8'(ox);
        @(negedge i_clk);
        i_cfg_addr <= CFG_ORIGIN_Y;   i_cfg_wdata <= 8'(oy);
        @(negedge i_clk);
        i_cfg_addr <= CFG_WIDTH;      i_cfg_wdata <= 8'(w);
        @(negedge i_clk);
        i_cfg_addr <= CFG_HEIGHT;     i_cfg_wdata <= 8'(h);
        @(negedge i_clk);
        i_cfg_addr <= CFG_GRID_READY; i_cfg_wdata <= 8'(rdy);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_ox = ox;
        cur_oy = oy;
        cur_w  = (w > 8) ? 8 : ((w > 256 - ox) ? 256 - ox : w);
        cur_h  = (h > 8) ? 8 : ((h > 256 - oy) ? 256 - oy : h);
    endtask

    // Random traffic: mostly searches and dynamic marks aimed inside the grid,
    // frequent clears so the grid does not silt up, and some fully random noise
    // that lands anywhere in the 8-bit coordinate space.
    task automatic random_traffic(int count, int gap_pct);
        int pick;
        logic [1:0] op;
        logic [7:0] x, y, gx, gy;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            x  = 8'(cur_ox + $urandom_range(0, cur_w - 1));
            y  = 8'(cur_oy + $urandom_range(0, cur_h - 1));
            gx = 8'(cur_ox + $urandom_range(0, cur_w - 1));
            gy = 8'(cur_oy + $urandom_range(0, cur_h - 1));
            if (pick < 45)       op = OP_SEARCH;
            else if (pick < 70)  op = OP_MARK_DYNAMIC;
            else if (pick < 76)  op = OP_MARK_STATIC;
            else if (pick < 88)  op = OP_CLEAR_DYN;
            else begin
                op = 2'($urandom_range(0, 3));
                x  = 8'($urandom_range(0, 255));
                y  = 8'($urandom_range(0, 255));
                gx = 8'($urandom_range(0, 255));
                gy = 8'($urandom_range(0, 255));
            end
            send_request(op, x, y, gx, gy);
            sender_gap(gap_pct);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = OP_MARK_STATIC;
        i_cell_x    = '0;
        i_cell_y    = '0;
        i_goal_x    = '0;
        i_goal_y    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_ORIGIN_X;
        i_cfg_wdata = '0;
        cur_ox = 0; cur_oy = 0; cur_w = 8; cur_h = 8;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Searches before the grid is declared ready are
        // refused, whatever the cells.
        send_request(OP_SEARCH, 8'd0, 8'd0, 8'd7, 8'd7);
        drain_idle();
        write_grid(0, 0, 8, 8, 1'b1);

        // Both full diagonals on an empty grid, then the refusal cases: start equal
        // to goal, goal or start off the grid.
        send_request(OP_SEARCH, 8'd0, 8'd0, 8'd7, 8'd7);
        send_request(OP_SEARCH, 8'd7, 8'd0, 8'd0, 8'd7);
        send_request(OP_SEARCH, 8'd3, 8'd3, 8'd3, 8'd3);
        send_request(OP_SEARCH, 8'd0, 8'd0, 8'd8, 8'd0);
        send_request(OP_SEARCH, 8'd255, 8'd255, 8'd1, 8'd1);
        // Marks at the corners and off the grid.
        send_request(OP_MARK_STATIC, 8'd0, 8'd7, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd7, 8'd0, 8'd255, 8'd255);
        send_request(OP_MARK_STATIC, 8'd8, 8'd0, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd0, 8'd255, 8'd0, 8'd0);
        // Blocked start and blocked goal give no path.
        send_request(OP_SEARCH, 8'd0, 8'd7, 8'd4, 8'd4);
        send_request(OP_SEARCH, 8'd4, 8'd4, 8'd7, 8'd0);
        // Wall the goal in so the open list runs dry.
        send_request(OP_MARK_DYNAMIC, 8'd6, 8'd6, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd6, 8'd7, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd7, 8'd6, 8'd0, 8'd0);
        send_request(OP_SEARCH, 8'd0, 8'd0, 8'd7, 8'd7);
        // A static mark later marked dynamic is freed by a clear.
        send_request(OP_MARK_DYNAMIC, 8'd0, 8'd7, 8'd0, 8'd0);
        send_request(OP_CLEAR_DYN, 8'd0, 8'd0, 8'd0, 8'd0);
        // Detour round a partial wall, diagonal corner cutting allowed.
        send_request(OP_MARK_DYNAMIC, 8'd3, 8'd2, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd3, 8'd3, 8'd0, 8'd0);
        send_request(OP_MARK_DYNAMIC, 8'd3, 8'd4, 8'd0, 8'd0);
        send_request(OP_SEARCH, 8'd0, 8'd3, 8'd7, 8'd3);
        send_request(OP_CLEAR_DYN, 8'd0, 8'd0, 8'd0, 8'd0);

        // Random phases: the sender idles often, then very often, then never.
        random_traffic(25, 35);
        drain_idle();
        write_grid(200, 100, 5, 3, 1'b1);
        random_traffic(25, 88);
        drain_idle();
        write_grid(248, 255, 15, 1, 1'b1);
        random_traffic(15, 0);
        drain_idle();
        write_grid(255, 0, 8, 8, 1'b1);
        random_traffic(10, 0);
        drain_idle();
        write_grid(0, 0, 1, 8, 1'b1);
        random_traffic(15, 0);
        drain_idle();
        write_grid(16, 32, 8, 8, 1'b0);
        random_traffic(10, 0);

        drain_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("PASS grid_astar_path_search_core");
        end else begin
            $display("FAIL grid_astar_path_search_core");
        end
        $finish;
    end

endmodule
